FILE: hdl/glu_pkg.sv
// Package with the transaction types, sequencer states and control structs of the gcd/lcm unit.
`timescale 1ns / 1ps

package glu_pkg;

  // Width of every numeric field on the ports.
  localparam int unsigned FIELD_W = 32;

  // Input transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } glu_in_t;

  // Result transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] divisor_out;
    logic [FIELD_W-1:0] multiple_out;
    logic               multiple_overflow;
  } glu_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EDIV,
    ST_QDIV,
    ST_MUL,
    ST_FIN
  } glu_state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic ready;
    logic load;
    logic div_init;
    logic div_sel_q;
    logic div_step;
    logic euc_update;
    logic mul_init;
    logic mul_step;
    logic zero_lcm;
    logic out_load;
  } glu_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic y_zero;
    logic op_zero;
    logic out_free;
  } glu_stat_t;

endpackage

FILE: hdl/glu_addsub.sv
// Shared adder/subtractor used for every divide and multiply step.
`timescale 1ns / 1ps

module glu_addsub #(
  parameter int unsigned WIDTH = 33
) (
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             carry
);

  logic [WIDTH-1:0] op_b_eff;

  // Two's complement subtract: invert the second operand and add one.
  assign op_b_eff = sub ? ~op_b : op_b;
  assign {carry, sum} = {1'b0, op_a} + {1'b0, op_b_eff} + {{WIDTH{1'b0}}, sub};

endmodule

FILE: hdl/glu_seq.sv
// Sequencer that steps the shared unit through Euclid, the quotient and the product.
`timescale 1ns / 1ps

module glu_seq #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  glu_pkg::glu_stat_t stat,
  output glu_pkg::glu_ctrl_t ctrl
);
  import glu_pkg::*;

  localparam int unsigned CW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

  glu_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          cnt_last;

  assign cnt_last = (cnt_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.y_zero) begin
          state_nxt = stat.op_zero ? ST_FIN : ST_QDIV;
        end else begin
          state_nxt = ST_EDIV;
        end
      end
      ST_EDIV: begin
        if (cnt_last) state_nxt = ST_CHECK;
      end
      ST_QDIV: begin
        if (cnt_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.ready = 1'b1;
        ctrl.load  = in_valid;
      end
      ST_CHECK: begin
        if (stat.y_zero) begin
          if (stat.op_zero) begin
            ctrl.zero_lcm = 1'b1;
          end else begin
            ctrl.div_init  = 1'b1;
            ctrl.div_sel_q = 1'b1;
          end
        end else begin
          ctrl.div_init = 1'b1;
        end
      end
      ST_EDIV: begin
        ctrl.div_step   = 1'b1;
        ctrl.euc_update = cnt_last;
      end
      ST_QDIV: begin
        ctrl.div_step = 1'b1;
        ctrl.mul_init = cnt_last;
      end
      ST_MUL: begin
        ctrl.mul_step = 1'b1;
      end
      ST_FIN: begin
        ctrl.out_load = stat.out_free;
      end
      default: ctrl = '0;
    endcase
  end

  // Step counter: one pass over all operand bits per divide or multiply.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.div_init || ctrl.mul_init) begin
      cnt_nxt = CW'(OPERAND_WIDTH - 1);
    end else if (ctrl.div_step || ctrl.mul_step) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/gcd_lcm_unit.sv
// Top level of the gcd/lcm unit: operand and working registers, shared unit and result register.
`timescale 1ns / 1ps

// The unit takes one transaction of two unsigned operands and returns their greatest
// common divisor and least common multiple, with a flag when the exact multiple does not
// fit in OPERAND_WIDTH bits (the multiple then holds its low bits). Operand bits above
// OPERAND_WIDTH are ignored. All arithmetic runs through one shared adder/subtractor,
// one bit per cycle: each Euclid remainder step is a restoring division, then a/gcd is
// found by another restoring division, then the product (a/gcd) * b by shift-add, and
// the result is loaded last. With a zero operand the quotient and product are skipped
// and the multiple is zero. The input is stalled from acceptance until the result is
// loaded. The result sits in an output register, so a new transaction is accepted while
// the previous result is still stalled.
module gcd_lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  glu_pkg::glu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output glu_pkg::glu_out_t out_data
);
  import glu_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  glu_ctrl_t ctrl;
  glu_stat_t stat;

  logic [W-1:0] a_r, b_r;
  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] y_r, y_nxt;
  logic [W-1:0] dvd_r, dvd_nxt;
  logic [W-1:0] dsr_r, dsr_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  glu_out_t     out_data_r;
  logic         out_valid_r, out_valid_nxt;

  logic [W:0]   alu_a, alu_b, alu_sum;
  logic         alu_sub, alu_carry;
  logic [W:0]   rem_sh;
  logic [W-1:0] div_rem;
  logic [W-1:0] div_dvd;

  // Sequencer.
  glu_seq #(
    .OPERAND_WIDTH(W)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  assign stat.y_zero   = (y_r == '0);
  assign stat.op_zero  = (a_r == '0) || (b_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Operand select for the shared unit: restoring divide step or shift-add multiply step.
  assign rem_sh = {rem_r, dvd_r[W-1]};
  always_comb begin
    if (ctrl.mul_step) begin
      alu_a   = {1'b0, rem_r};
      alu_b   = dvd_r[0] ? {1'b0, b_r} : '0;
      alu_sub = 1'b0;
    end else begin
      alu_a   = rem_sh;
      alu_b   = {1'b0, dsr_r};
      alu_sub = 1'b1;
    end
  end

  glu_addsub #(
    .WIDTH(W + 1)
  ) u_addsub (
    .op_a (alu_a),
    .op_b (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .carry(alu_carry)
  );

  // Divide step result: a carry out means no borrow, so the trial subtract is kept.
  assign div_rem = alu_carry ? alu_sum[W-1:0] : rem_sh[W-1:0];
  assign div_dvd = {dvd_r[W-2:0], alu_carry};

  // Working register updates.
  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    if (ctrl.load) begin
      x_nxt = W'(in_data.operand_a);
      y_nxt = W'(in_data.operand_b);
    end else if (ctrl.euc_update) begin
      x_nxt = dsr_r;
      y_nxt = div_rem;
    end
    if (ctrl.div_init) begin
      dvd_nxt = ctrl.div_sel_q ? a_r : x_r;
      dsr_nxt = ctrl.div_sel_q ? x_r : y_r;
    end else if (ctrl.zero_lcm) begin
      dvd_nxt = '0;
    end else if (ctrl.div_step) begin
      dvd_nxt = div_dvd;
    end else if (ctrl.mul_step) begin
      dvd_nxt = {alu_sum[0], dvd_r[W-1:1]};
    end
    if (ctrl.div_init || ctrl.mul_init || ctrl.zero_lcm) begin
      rem_nxt = '0;
    end else if (ctrl.div_step) begin
      rem_nxt = div_rem;
    end else if (ctrl.mul_step) begin
      rem_nxt = alu_sum[W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= W'(in_data.operand_a);
      b_r <= W'(in_data.operand_b);
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  // Result register: gcd in x, product low half in dvd, high half in rem.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data_r.divisor_out       <= FIELD_W'(x_r);
      out_data_r.multiple_out      <= FIELD_W'(dvd_r);
      out_data_r.multiple_overflow <= (rem_r != '0);
    end
  end

  assign in_stall  = !ctrl.ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/glu_checker.sv
// Port-level checker for the gcd/lcm unit and the bind that attaches it.
`timescale 1ns / 1ps

module glu_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input glu_pkg::glu_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input glu_pkg::glu_out_t out_data
);
  import glu_pkg::*;

  // A stalled result transaction stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // After an input transaction is taken the unit is busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // A result cannot appear in the cycle right after an input transaction is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A zero divisor means a zero operand, so the multiple is zero with no overflow.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.divisor_out == '0) |->
      (out_data.multiple_out == '0) && !out_data.multiple_overflow)
    else $error("nonzero multiple with zero divisor");

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (.*);
